FILE: rtl/c2d_pkg.sv
// c2d_pkg: shared constants, types and a clamp helper for the 5x5 convolution unit
// no dependencies; imported by conv2d_5x5_fixed_point_unit
package c2d_pkg;

	localparam int MAX_WIDTH = 256;
	localparam int ROW_LEN   = MAX_WIDTH + 4;
	localparam int COL_W     = $clog2(ROW_LEN);
	localparam int COL_MAX   = ROW_LEN - 1;
	localparam int TAPS      = 25;
	localparam int LINES     = 4;

	localparam int PROD_W    = 24;
	localparam int RSUM_W    = 25;
	localparam int TOTAL_W   = 28;
	localparam int SCALED_W  = 21;

	localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;
	localparam logic signed [15:0] SAT_POS    = 16'sd32767;
	localparam logic signed [15:0] SAT_NEG    = -16'sd32767;

	typedef logic [COL_W-1:0] col_t;
	typedef logic signed [15:0] sample_t;
	typedef logic [16*LINES-1:0] line_word_t;

	typedef enum logic [2:0] {
		REG_KPACK0,
		REG_KPACK1,
		REG_KPACK2,
		REG_KPACK3,
		REG_KPACK4,
		REG_KPACK5,
		REG_KPACK6,
		REG_OUT_WIDTH
	} reg_idx_t;

	function automatic sample_t clip_min(input sample_t x);
		return (x == SAMPLE_MIN) ? SAT_NEG : x;
	endfunction

endpackage

FILE: rtl/conv2d_5x5_fixed_point_unit.sv
// conv2d_5x5_fixed_point_unit: streaming 5x5 fixed-point convolution with line store
// depends on c2d_pkg
//
// Takes one padded-frame pixel per cycle while pixel_stall is low (out_width+4 per
// row, row-major) and returns one clamped result per complete 5x5 window, one per
// cycle sustained while conv_stall is low. The four previous rows sit in one 260 x
// 64-bit synchronous RAM, one word per column, read when a pixel is accepted and
// written back when that pixel leaves the line stage; a bypass covers a re-read of
// the column just written. Stages in order: line read at the accepting edge, window
// capture, 25 tap multipliers, row sums, and final sum and clamp. Stall propagates
// back only through occupied stages. The line store has no clearing pass and needs
// none: the feeder fills four rows before any result uses them. The user must write
// registers only while idle; the block itself does not enforce it.
module conv2d_5x5_fixed_point_unit
	import c2d_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  logic signed [15:0]   pixel,
	input  logic                 frame_start,
	output logic                 conv_valid,
	input  logic                 conv_stall,
	output logic signed [15:0]   conv_value,
	output logic                 row_end
);

	logic [63:0] kpack_q [0:5];
	logic [15:0] kpack6_q;
	logic [8:0]  out_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) kpack_q[i] <= '0;
			kpack6_q    <= '0;
			out_width_q <= 9'd64;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_KPACK0:    kpack_q[0] <= cfg_data;
				REG_KPACK1:    kpack_q[1] <= cfg_data;
				REG_KPACK2:    kpack_q[2] <= cfg_data;
				REG_KPACK3:    kpack_q[3] <= cfg_data;
				REG_KPACK4:    kpack_q[4] <= cfg_data;
				REG_KPACK5:    kpack_q[5] <= cfg_data;
				REG_KPACK6:    kpack6_q <= cfg_data[15:0];
				REG_OUT_WIDTH: out_width_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	sample_t coef [0:TAPS-1];

	for (genvar k = 0; k < TAPS - 1; k++) begin : g_coef
		assign coef[k] = kpack_q[k/4][16*(k%4) +: 16];
	end
	assign coef[TAPS-1] = kpack6_q;

	// pipeline control
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic adv1, adv2, adv3, adv4, adv5, leave1, accept;
	logic emit_s1, last_s1, last_s2, last_s3, last_s4;

	assign adv5   = ~v5_q | ~conv_stall;
	assign adv4   = ~v4_q | adv5;
	assign adv3   = ~v3_q | adv4;
	assign adv2   = ~v2_q | adv3;
	assign leave1 = v1_q & (~emit_s1 | adv2);
	assign adv1   = ~v1_q | leave1;
	assign accept = pixel_valid & adv1;
	assign pixel_stall = ~adv1;

	// column and row tracking
	col_t       column_count_q;
	logic [2:0] rows_seen_q;
	col_t       w_eff, padded, col_raw, col_cur;
	logic [2:0] rows_cur;
	logic       emit_cur, last_cur;

	always_comb begin
		if (out_width_q == '0)
			w_eff = COL_W'(1);
		else if (32'(out_width_q) > MAX_WIDTH)
			w_eff = COL_W'(MAX_WIDTH);
		else
			w_eff = COL_W'(out_width_q);
		padded   = w_eff + COL_W'(4);
		col_raw  = frame_start ? '0 : column_count_q;
		col_cur  = (32'(col_raw) > COL_MAX) ? COL_W'(COL_MAX) : col_raw;
		rows_cur = frame_start ? 3'd0 : rows_seen_q;
		emit_cur = (rows_cur >= 3'd4) && (col_cur >= COL_W'(4));
		last_cur = (col_cur >= padded - COL_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			rows_seen_q    <= '0;
		end else if (accept) begin
			column_count_q <= last_cur ? '0 : col_cur + COL_W'(1);
			rows_seen_q    <= (last_cur && rows_cur < 3'd4) ? rows_cur + 3'd1 : rows_cur;
		end
	end

	// line store: one word per column, oldest row in the low lane
	line_word_t line_mem [0:ROW_LEN-1];
	line_word_t rd_s1, wdata;
	col_t       col_s1;
	sample_t    px_s1;

	assign wdata = {px_s1, rd_s1[16*LINES-1:16]};

	always_ff @(posedge clk) begin
		if (leave1)
			line_mem[col_s1] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1   <= (v1_q && col_s1 == col_cur) ? wdata : line_mem[col_cur];
			col_s1  <= col_cur;
			px_s1   <= pixel;
			emit_s1 <= emit_cur;
			last_s1 <= last_cur;
		end
	end

	// window
	sample_t win_q  [0:TAPS-1];
	sample_t win_nx [0:TAPS-1];
	sample_t win_s2 [0:TAPS-1];

	always_comb begin
		for (int r = 0; r < 5; r++)
			for (int c = 0; c < 4; c++)
				win_nx[r*5+c] = win_q[r*5+c+1];
		for (int r = 0; r < LINES; r++)
			win_nx[r*5+4] = rd_s1[16*r +: 16];
		win_nx[TAPS-1] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) win_q[i] <= '0;
		end else if (leave1) begin
			win_q <= win_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			win_s2  <= win_nx;
			last_s2 <= last_s1;
		end
	end

	// tap products
	logic signed [PROD_W-1:0] prod_s3 [0:TAPS-1];
	logic signed [PROD_W-1:0] prod_nx [0:TAPS-1];

	always_comb begin
		logic signed [31:0] p;
		for (int k = 0; k < TAPS; k++) begin
			p = clip_min(win_s2[k]) * clip_min(coef[k]);
			prod_nx[k] = p[30:7];
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			prod_s3 <= prod_nx;
			last_s3 <= last_s2;
		end
	end

	// row sums
	logic signed [RSUM_W-1:0] rsum_s4 [0:4];
	logic signed [RSUM_W-1:0] rsum_nx [0:4];

	always_comb begin
		logic signed [RSUM_W+1:0] acc;
		for (int r = 0; r < 5; r++) begin
			acc = '0;
			for (int c = 0; c < 5; c++)
				acc = acc + (RSUM_W+2)'(prod_s3[r*5+c]);
			rsum_nx[r] = acc[RSUM_W+1:2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			rsum_s4 <= rsum_nx;
			last_s4 <= last_s3;
		end
	end

	// final sum, scale and clamp
	logic signed [TOTAL_W-1:0]  total;
	logic signed [SCALED_W-1:0] scaled;
	sample_t                    result_nx;

	always_comb begin
		total = '0;
		for (int r = 0; r < 5; r++)
			total = total + TOTAL_W'(rsum_s4[r]);
		scaled = total[TOTAL_W-1:7];
		if (scaled > SCALED_W'(SAT_POS))
			result_nx = SAT_POS;
		else if (scaled < SCALED_W'(SAT_NEG))
			result_nx = SAT_NEG;
		else
			result_nx = scaled[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			conv_value <= result_nx;
			row_end    <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= pixel_valid;
			if (adv2) v2_q <= leave1 & emit_s1;
			if (adv3) v3_q <= v2_q;
			if (adv4) v4_q <= v3_q;
			if (adv5) v5_q <= v4_q;
		end
	end

	assign conv_valid = v5_q;

	a_stall_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> v1_q)
		else $error("input stalled with empty line stage");

	a_column_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(column_count_q) <= COL_MAX)
		else $error("column count past padded row length");

	a_window_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(leave1 && emit_s1) |=> v2_q)
		else $error("complete window lost before multiply stage");

endmodule
